[rtl/gbu_pkg.sv]
// Shared types, codes and defaults of the gap buffer text store.
package gbu_pkg;

	// Default sizes
	localparam int CAPACITY_DEF = 4096;
	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int SAVED_BYTES_DEF = 4096;

	// Width of the position, count and length fields
	localparam int FW = 13;

	// Request codes
	localparam logic [2:0] REQ_INS = 3'd0;
	localparam logic [2:0] REQ_DEL = 3'd1;
	localparam logic [2:0] REQ_MOVE = 3'd2;
	localparam logic [2:0] REQ_UNDO = 3'd3;
	localparam logic [2:0] REQ_REDO = 3'd4;
	localparam logic [2:0] REQ_READ = 3'd5;

	// History entry kinds
	localparam logic KIND_INS = 1'b0;
	localparam logic KIND_DEL = 1'b1;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_RANGE  = 3'd1,
		ST_FULL   = 3'd2,
		ST_NOUNDO = 3'd3,
		ST_NOREDO = 3'd4,
		ST_BUSY   = 3'd5
	} status_t;

	// Micro commands from the controller to the datapath
	typedef struct packed {
		logic    latch;
		logic    ins;
		logic    rd_text;
		logic    tgt_pos;
		logic    tgt_ent;
		logic    mv_rd;
		logic    mv_wr;
		logic    hist_rd;
		logic    hist_redo;
		logic    ent_ld;
		logic    del_begin;
		logic    cut;
		logic    cp_clr;
		logic    cp_rd;
		logic    cp_wr;
		logic    cp_paste;
		logic    del_end;
		logic    undo_end;
		logic    redo_end;
		logic    fin;
		logic    fin_rd;
		status_t code;
	} cmd_t;

	// Conditions reported by the datapath
	typedef struct packed {
		logic [2:0] typ;
		logic       full;
		logic       run_open;
		logic       del_bad;
		logic       mv_bad;
		logic       rd_bad;
		logic       top_zero;
		logic       redo_bad;
		logic       ent_ins;
		logic       cut_fit;
		logic       paste_fit;
		logic       at_tgt;
		logic       del_rec;
		logic       copy_done;
	} stat_t;

endpackage

[rtl/gbu_datapath.sv]
// Datapath: text, saved-byte and history memories, gap pointers and counters.
module gbu_datapath #(
	parameter int CAPACITY = gbu_pkg::CAPACITY_DEF,
	parameter int HISTORY_DEPTH = gbu_pkg::HISTORY_DEPTH_DEF,
	parameter int SAVED_BYTES = gbu_pkg::SAVED_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gbu_pkg::cmd_t           cmd,
	output gbu_pkg::stat_t          stat,
	input  logic [2:0]              req_type,
	input  logic [7:0]              data_byte,
	input  logic                    last,
	input  logic [gbu_pkg::FW-1:0]  position,
	input  logic [gbu_pkg::FW-1:0]  count,
	output logic                    done,
	output logic [2:0]              status,
	output logic [7:0]              read_data,
	output logic [gbu_pkg::FW-1:0]  doc_length,
	output logic                    can_undo,
	output logic                    can_redo,
	output logic                    modified
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(SAVED_BYTES + 1);
	localparam int IW0 = (CW > SW) ? CW : SW;
	localparam int IW = (IW0 > gbu_pkg::FW) ? IW0 : gbu_pkg::FW;
	localparam int AW = $clog2(CAPACITY);
	localparam int SAW = $clog2(SAVED_BYTES);
	localparam int HAW = $clog2(HISTORY_DEPTH);
	localparam int HW = $clog2(HISTORY_DEPTH + 1);
	localparam int EW = 1 + 3 * IW;
	localparam logic [IW-1:0] CAP_V = IW'(CAPACITY);
	localparam logic [IW-1:0] SB_V = IW'(SAVED_BYTES);
	localparam logic [HW-1:0] HD_V = HW'(HISTORY_DEPTH);

	// Memories
	logic [7:0]    text_mem [CAPACITY];
	logic [7:0]    saved_mem [SAVED_BYTES];
	logic [EW-1:0] hist_mem [HISTORY_DEPTH];

	// Request registers
	logic [2:0]    typ_q;
	logic [7:0]    byte_q;
	logic          last_q;
	logic [IW-1:0] pos_q, cnt_q;

	// Store state
	logic [IW-1:0] gf_q, ga_q, fill_q;
	logic [HW-1:0] top_q, redo_q;
	logic          run_q, logged_q, edited_q, rec_q, done_q;

	// Working registers
	logic [IW-1:0] tgt_q, i_q;
	logic          ekind_q;
	logic [IW-1:0] epos_q, elen_q, eoff_q;
	logic [7:0]    txt_q, sav_q, rd_q;
	logic [EW-1:0] hist_q;
	gbu_pkg::status_t status_q;

	// Derived values
	logic [IW-1:0] gsize, len, gf_m1, ga_m1, ga_pi, eoff_pi, fill_pi, rd_addr;
	logic [HW-1:0] top_m1;
	logic          full, mv_down, fresh_ok, fill_room;

	// Memory ports
	logic          t_we, t_re, s_we, s_re, h_we, h_re;
	logic [AW-1:0] t_wa, t_ra;
	logic [SAW-1:0] s_wa, s_ra;
	logic [HAW-1:0] h_wa, h_ra;
	logic [7:0]    t_wd, s_wd;
	logic [EW-1:0] h_wd;

	assign gsize = ga_q - gf_q;
	assign len = CAP_V - gsize;
	assign gf_m1 = gf_q - IW'(1);
	assign ga_m1 = ga_q - IW'(1);
	assign ga_pi = ga_q + i_q;
	assign eoff_pi = eoff_q + i_q;
	assign fill_pi = fill_q + i_q;
	assign rd_addr = (pos_q < gf_q) ? pos_q : pos_q + gsize;
	assign top_m1 = top_q - HW'(1);
	assign full = (gf_q == ga_q);
	assign mv_down = (tgt_q < gf_q);
	assign fill_room = (fill_q < SB_V);
	assign fresh_ok = (top_q < HD_V) && fill_room;

	// Report conditions
	always_comb begin
		stat.typ = typ_q;
		stat.full = full;
		stat.run_open = run_q;
		stat.del_bad = (cnt_q == '0) || (pos_q > len) || (cnt_q > len - pos_q);
		stat.mv_bad = (pos_q > len);
		stat.rd_bad = (pos_q >= len);
		stat.top_zero = (top_q == '0);
		stat.redo_bad = (redo_q == '0) || (top_q >= HD_V);
		stat.ent_ins = (ekind_q == gbu_pkg::KIND_INS);
		stat.cut_fit = (epos_q <= len) && (elen_q <= len - epos_q);
		stat.paste_fit = (epos_q <= len) && (elen_q <= gsize) && (eoff_q <= SB_V) &&
			(elen_q <= SB_V - eoff_q);
		stat.at_tgt = (tgt_q == gf_q);
		stat.del_rec = (top_q < HD_V) && (cnt_q <= SB_V - fill_q);
		stat.copy_done = (i_q == elen_q);
	end

	// Steer memory ports
	always_comb begin
		t_we = 1'b0; t_wa = '0; t_wd = '0; t_re = 1'b0; t_ra = '0;
		s_we = 1'b0; s_wa = '0; s_wd = '0; s_re = 1'b0; s_ra = '0;
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_re = 1'b0; h_ra = '0;
		if (cmd.ins && !full) begin
			t_we = 1'b1;
			t_wa = gf_q[AW-1:0];
			t_wd = byte_q;
			if (!run_q) begin
				if (fresh_ok) begin
					s_we = 1'b1;
					s_wa = fill_q[SAW-1:0];
					s_wd = byte_q;
					h_we = 1'b1;
					h_wa = top_q[HAW-1:0];
					h_wd = {gbu_pkg::KIND_INS, gf_q, IW'(1), fill_q};
				end
			end else if (logged_q && fill_room) begin
				s_we = 1'b1;
				s_wa = fill_q[SAW-1:0];
				s_wd = byte_q;
				h_we = 1'b1;
				h_wa = top_m1[HAW-1:0];
				h_wd = {gbu_pkg::KIND_INS, epos_q, elen_q + IW'(1), eoff_q};
			end
		end
		if (cmd.mv_wr) begin
			t_we = 1'b1;
			t_wa = mv_down ? ga_m1[AW-1:0] : gf_q[AW-1:0];
			t_wd = txt_q;
		end
		if (cmd.cp_wr && cmd.cp_paste) begin
			t_we = 1'b1;
			t_wa = gf_q[AW-1:0];
			t_wd = sav_q;
		end
		if (cmd.cp_wr && !cmd.cp_paste) begin
			s_we = 1'b1;
			s_wa = fill_pi[SAW-1:0];
			s_wd = txt_q;
		end
		if (cmd.del_begin && stat.del_rec) begin
			h_we = 1'b1;
			h_wa = top_q[HAW-1:0];
			h_wd = {gbu_pkg::KIND_DEL, pos_q, cnt_q, fill_q};
		end
		if (cmd.rd_text) begin
			t_re = 1'b1;
			t_ra = rd_addr[AW-1:0];
		end
		if (cmd.mv_rd) begin
			t_re = 1'b1;
			t_ra = mv_down ? gf_m1[AW-1:0] : ga_q[AW-1:0];
		end
		if (cmd.cp_rd && !cmd.cp_paste) begin
			t_re = 1'b1;
			t_ra = ga_pi[AW-1:0];
		end
		if (cmd.cp_rd && cmd.cp_paste) begin
			s_re = 1'b1;
			s_ra = eoff_pi[SAW-1:0];
		end
		if (cmd.hist_rd) begin
			h_re = 1'b1;
			h_ra = cmd.hist_redo ? top_q[HAW-1:0] : top_m1[HAW-1:0];
		end
	end

	// Text memory
	always_ff @(posedge clk) begin
		if (t_we) text_mem[t_wa] <= t_wd;
		if (t_re) txt_q <= text_mem[t_ra];
	end

	// Saved-byte memory
	always_ff @(posedge clk) begin
		if (s_we) saved_mem[s_wa] <= s_wd;
		if (s_re) sav_q <= saved_mem[s_ra];
	end

	// History memory
	always_ff @(posedge clk) begin
		if (h_we) hist_mem[h_wa] <= h_wd;
		if (h_re) hist_q <= hist_mem[h_ra];
	end

	// Update store state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gf_q <= '0;
			ga_q <= CAP_V;
			fill_q <= '0;
			top_q <= '0;
			redo_q <= '0;
			run_q <= 1'b0;
			logged_q <= 1'b0;
			edited_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.ins) begin
				if (full) begin
					if (run_q && last_q) begin
						run_q <= 1'b0;
						logged_q <= 1'b0;
					end
				end else begin
					redo_q <= '0;
					gf_q <= gf_q + IW'(1);
					edited_q <= 1'b1;
					run_q <= !last_q;
					if (!run_q) begin
						if (fresh_ok) begin
							fill_q <= fill_q + IW'(1);
							top_q <= top_q + HW'(1);
							logged_q <= !last_q;
						end else begin
							logged_q <= 1'b0;
						end
					end else if (logged_q) begin
						if (fill_room) begin
							fill_q <= fill_q + IW'(1);
							logged_q <= !last_q;
						end else begin
							fill_q <= eoff_q;
							top_q <= top_m1;
							logged_q <= 1'b0;
						end
					end
				end
			end
			if (cmd.mv_wr) begin
				if (mv_down) begin
					gf_q <= gf_m1;
					ga_q <= ga_m1;
				end else begin
					gf_q <= gf_q + IW'(1);
					ga_q <= ga_q + IW'(1);
				end
			end
			if (cmd.del_begin) redo_q <= '0;
			if (cmd.cut) ga_q <= ga_q + elen_q;
			if (cmd.cp_wr && cmd.cp_paste) gf_q <= gf_q + IW'(1);
			if (cmd.del_end) begin
				if (rec_q) begin
					fill_q <= fill_q + elen_q;
					top_q <= top_q + HW'(1);
				end
				ga_q <= ga_q + elen_q;
				edited_q <= 1'b1;
			end
			if (cmd.undo_end) begin
				fill_q <= eoff_q;
				top_q <= top_m1;
				redo_q <= redo_q + HW'(1);
			end
			if (cmd.redo_end) begin
				fill_q <= eoff_q + elen_q;
				top_q <= top_q + HW'(1);
				redo_q <= redo_q - HW'(1);
			end
		end
	end

	// Hold request, entry and result words
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			typ_q <= req_type;
			byte_q <= data_byte;
			last_q <= last;
			pos_q <= IW'(position);
			cnt_q <= IW'(count);
		end
		if (cmd.ins && !full) begin
			if (!run_q) begin
				ekind_q <= gbu_pkg::KIND_INS;
				epos_q <= gf_q;
				elen_q <= IW'(1);
				eoff_q <= fill_q;
			end else if (logged_q && fill_room) begin
				elen_q <= elen_q + IW'(1);
			end
		end
		if (cmd.tgt_pos) tgt_q <= pos_q;
		if (cmd.tgt_ent) tgt_q <= epos_q;
		if (cmd.ent_ld) {ekind_q, epos_q, elen_q, eoff_q} <= hist_q;
		if (cmd.del_begin) begin
			elen_q <= cnt_q;
			eoff_q <= fill_q;
			rec_q <= stat.del_rec;
		end
		if (cmd.del_begin || cmd.cp_clr) i_q <= '0;
		if (cmd.cp_wr) i_q <= i_q + IW'(1);
		if (cmd.fin) begin
			status_q <= cmd.code;
			rd_q <= cmd.fin_rd ? txt_q : 8'd0;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign read_data = rd_q;
	assign doc_length = len[gbu_pkg::FW-1:0];
	assign can_undo = (top_q != '0);
	assign can_redo = (redo_q != '0);
	assign modified = edited_q;

endmodule

[rtl/gbu_ctrl.sv]
// Controller: sequences each request into datapath micro commands.
module gbu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gbu_pkg::stat_t stat,
	output gbu_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_DEC  = 11'b00000000010,
		S_RDW  = 11'b00000000100,
		S_MV   = 11'b00000001000,
		S_MVW  = 11'b00000010000,
		S_HRD  = 11'b00000100000,
		S_HCHK = 11'b00001000000,
		S_ACT  = 11'b00010000000,
		S_CPR  = 11'b00100000000,
		S_CPW  = 11'b01000000000,
		S_END  = 11'b10000000000
	} state_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_DEL   = 2'd1,
		ACT_CUT   = 2'd2,
		ACT_PASTE = 2'd3
	} act_t;

	state_t state_q, state_d;
	act_t   act_q, act_d;
	logic   undo_q, undo_d;
	logic   paste;

	assign busy = (state_q != S_IDLE);
	assign paste = undo_q ^ stat.ent_ins;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		act_d = act_q;
		undo_d = undo_q;
		cmd = '0;
		cmd.code = gbu_pkg::ST_OK;
		cmd.cp_paste = (act_q == ACT_PASTE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				if (stat.typ == gbu_pkg::REQ_INS) begin
					cmd.ins = 1'b1;
					cmd.fin = 1'b1;
					cmd.code = stat.full ? gbu_pkg::ST_FULL : gbu_pkg::ST_OK;
				end else if (stat.typ > gbu_pkg::REQ_READ) begin
					cmd.fin = 1'b1;
					cmd.code = gbu_pkg::ST_RANGE;
				end else if (stat.run_open) begin
					cmd.fin = 1'b1;
					cmd.code = gbu_pkg::ST_BUSY;
				end else begin
					case (stat.typ)
						gbu_pkg::REQ_DEL: begin
							if (stat.del_bad) begin
								cmd.fin = 1'b1;
								cmd.code = gbu_pkg::ST_RANGE;
							end else begin
								cmd.tgt_pos = 1'b1;
								act_d = ACT_DEL;
								state_d = S_MV;
							end
						end
						gbu_pkg::REQ_MOVE: begin
							if (stat.mv_bad) begin
								cmd.fin = 1'b1;
								cmd.code = gbu_pkg::ST_RANGE;
							end else begin
								cmd.tgt_pos = 1'b1;
								act_d = ACT_NONE;
								state_d = S_MV;
							end
						end
						gbu_pkg::REQ_UNDO: begin
							if (stat.top_zero) begin
								cmd.fin = 1'b1;
								cmd.code = gbu_pkg::ST_NOUNDO;
							end else begin
								cmd.hist_rd = 1'b1;
								undo_d = 1'b1;
								state_d = S_HRD;
							end
						end
						gbu_pkg::REQ_REDO: begin
							if (stat.redo_bad) begin
								cmd.fin = 1'b1;
								cmd.code = gbu_pkg::ST_NOREDO;
							end else begin
								cmd.hist_rd = 1'b1;
								cmd.hist_redo = 1'b1;
								undo_d = 1'b0;
								state_d = S_HRD;
							end
						end
						default: begin
							if (stat.rd_bad) begin
								cmd.fin = 1'b1;
								cmd.code = gbu_pkg::ST_RANGE;
							end else begin
								cmd.rd_text = 1'b1;
								state_d = S_RDW;
							end
						end
					endcase
				end
			end
			S_RDW: begin
				cmd.fin = 1'b1;
				cmd.fin_rd = 1'b1;
				state_d = S_IDLE;
			end
			S_HRD: begin
				cmd.ent_ld = 1'b1;
				state_d = S_HCHK;
			end
			S_HCHK: begin
				if (paste ? stat.paste_fit : stat.cut_fit) begin
					cmd.tgt_ent = 1'b1;
					act_d = paste ? ACT_PASTE : ACT_CUT;
					state_d = S_MV;
				end else begin
					cmd.fin = 1'b1;
					cmd.code = gbu_pkg::ST_RANGE;
					state_d = S_IDLE;
				end
			end
			S_MV: begin
				if (stat.at_tgt) begin
					state_d = S_ACT;
				end else begin
					cmd.mv_rd = 1'b1;
					state_d = S_MVW;
				end
			end
			S_MVW: begin
				cmd.mv_wr = 1'b1;
				state_d = S_MV;
			end
			S_ACT: begin
				case (act_q)
					ACT_DEL: begin
						cmd.del_begin = 1'b1;
						state_d = stat.del_rec ? S_CPR : S_END;
					end
					ACT_CUT: begin
						cmd.cut = 1'b1;
						state_d = S_END;
					end
					ACT_PASTE: begin
						cmd.cp_clr = 1'b1;
						state_d = S_CPR;
					end
					default: begin
						cmd.fin = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_CPR: begin
				if (stat.copy_done) begin
					state_d = S_END;
				end else begin
					cmd.cp_rd = 1'b1;
					state_d = S_CPW;
				end
			end
			S_CPW: begin
				cmd.cp_wr = 1'b1;
				state_d = S_CPR;
			end
			S_END: begin
				if (act_q == ACT_DEL) cmd.del_end = 1'b1;
				else if (undo_q) cmd.undo_end = 1'b1;
				else cmd.redo_end = 1'b1;
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_NONE;
			undo_q <= 1'b0;
		end else begin
			state_q <= state_d;
			act_q <= act_d;
			undo_q <= undo_d;
		end
	end

endmodule

[rtl/gap_buffer_text_store_with_undo_unit.sv]
// Top level of the gap buffer text store with undo and redo.
//
// Usage: drive a request word (req_type, data_byte, last, position, count)
// and raise start; the word is taken at a clock edge where start is high and
// busy is low. Exactly one result word follows on status, read_data,
// doc_length, can_undo, can_redo and modified, marked by done for one cycle.
// The receiver cannot stall; the result must be taken in that cycle.
// Inserts, rejected requests and undo/redo refusals answer from the decode
// state; reads also pass through a read-wait state; an undo or redo whose
// entry no longer fits the text answers after its history read and check
// states. A cursor move is a read then a write per byte of gap travel,
// since each moved byte is read from the text memory into a register and
// then written back. Deletes add a read and a write per saved byte; undo
// and redo add a history read, the gap travel and a read and a write per
// restored byte. Busy is low again in the cycle that done is shown.
// Reset: empty text, gap over the whole store, no history, not modified.
// Memory contents are not cleared.
module gap_buffer_text_store_with_undo_unit #(
	parameter int CAPACITY = gbu_pkg::CAPACITY_DEF,
	parameter int HISTORY_DEPTH = gbu_pkg::HISTORY_DEPTH_DEF,
	parameter int SAVED_BYTES = gbu_pkg::SAVED_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [2:0]             req_type,
	input  logic [7:0]             data_byte,
	input  logic                   last,
	input  logic [gbu_pkg::FW-1:0] position,
	input  logic [gbu_pkg::FW-1:0] count,
	output logic                   done,
	output logic [2:0]             status,
	output logic [7:0]             read_data,
	output logic [gbu_pkg::FW-1:0] doc_length,
	output logic                   can_undo,
	output logic                   can_redo,
	output logic                   modified
);

	gbu_pkg::cmd_t  cmd;
	gbu_pkg::stat_t stat;

	gbu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	gbu_datapath #(
		.CAPACITY      (CAPACITY),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAVED_BYTES   (SAVED_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.last       (last),
		.position   (position),
		.count      (count),
		.done       (done),
		.status     (status),
		.read_data  (read_data),
		.doc_length (doc_length),
		.can_undo   (can_undo),
		.can_redo   (can_redo),
		.modified   (modified)
	);

	// A result word only appears once the controller is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while controller busy");

	// An accepted word makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// Unknown request types are answered with bad range
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type > gbu_pkg::REQ_READ)) |->
		##2 (done && (status == gbu_pkg::ST_RANGE)))
		else $error("unknown request not answered with bad range");

	// Inserts are answered from the decode state, through the done register
	a_insert_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == gbu_pkg::REQ_INS)) |-> ##2 done)
		else $error("insert result late");

endmodule
